>>> design/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg
// Shared constants, types and the exp table generator for the density sweep.
// ----------------------------------------------------------------------------
package gds_pkg;

    localparam int EXP_TABLE_DEPTH = 256;
    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH + 1);

    // restoring divider geometry
    localparam int DIV_W = 31;
    localparam int DVS_W = 15;
    localparam int CNT_W = $clog2(DIV_W);

    // round(2^24/sqrt(2*3.1416)) scaled by 2^8
    localparam logic [DIV_W-1:0] PEAK_NUM = DIV_W'(6693133 * 256);

    // configuration register indexes
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] CFG_MEAN  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_SIGMA = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_START = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_END   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_STEP  = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // floor(num/den) by shift and subtract, used only to build the table
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // 2^32*exp(-k/D), Taylor series in Q.40 rounded to Q.32
    function automatic logic [32:0] exp_entry(input int unsigned k);
        longint          sum;
        longint unsigned t;
        longint unsigned i;
        longint unsigned kk;
        sum = longint'(1) << 40;
        t   = longint'(1) << 40;
        i   = 1;
        kk  = longint'(k);
        while (t != 0 && i < 200) begin
            t = udiv64(t * kk, longint'(EXP_TABLE_DEPTH) * i);
            if (i[0]) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
            i = i + 1;
        end
        if (sum < 0) begin
            sum = 0;
        end
        return 33'((longint'(sum) + 128) >>> 8);
    endfunction

    // exp(-1) in Q.32
    localparam logic [31:0] EXP_LAST = 32'(exp_entry(EXP_TABLE_DEPTH));

endpackage

>>> design/gds_div.sv
// ----------------------------------------------------------------------------
// gds_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gds_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gds_pkg::DIV_W-1:0]   i_dividend,
    input  logic [gds_pkg::DVS_W-1:0]   i_divisor,
    output logic [gds_pkg::DIV_W-1:0]   o_quo,
    output gds_pkg::t_div_stat          o_stat
);

    logic                        r_busy;
    logic                        r_done;
    logic [gds_pkg::CNT_W-1:0]   r_cnt;
    logic [gds_pkg::DIV_W-1:0]   r_quo;
    logic [gds_pkg::DVS_W-1:0]   r_rem;
    logic [gds_pkg::DVS_W-1:0]   r_dvs;

    logic [gds_pkg::DVS_W:0]     w_trial;
    logic [gds_pkg::DVS_W:0]     w_diff;
    logic                        w_ge;

    assign w_trial = {r_rem, r_quo[gds_pkg::DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= gds_pkg::CNT_W'(gds_pkg::DIV_W - 1);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[gds_pkg::DIV_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[gds_pkg::DVS_W-1:0] : w_trial[gds_pkg::DVS_W-1:0];
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_quo       = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

>>> design/gds_mul.sv
// ----------------------------------------------------------------------------
// gds_mul
// Shared 33x32 multiplier with registered product. Bit 32 of a is only ever
// set with the low bits clear (the value 2^32), so it costs an add of b<<32.
// ----------------------------------------------------------------------------
module gds_mul (
    input  logic        i_clk,
    input  logic [32:0] i_a,
    input  logic [31:0] i_b,
    output logic [64:0] o_p
);

    logic [63:0] w_lo;
    logic [64:0] w_hi;
    logic [64:0] r_p;

    assign w_lo = 64'(i_a[31:0]) * 64'(i_b);
    assign w_hi = i_a[32] ? {1'b0, i_b, 32'd0} : 65'd0;

    always_ff @(posedge i_clk) begin
        r_p <= {1'b0, w_lo} + w_hi;
    end

    assign o_p = r_p;

endmodule

>>> design/gds_rom.sv
// ----------------------------------------------------------------------------
// gds_rom
// exp(-k/D) table in Q.32, k = 0..D, registered read.
// ----------------------------------------------------------------------------
module gds_rom (
    input  logic                        i_clk,
    input  logic [gds_pkg::IDX_W-1:0]   i_addr,
    output logic [32:0]                 o_data
);

    logic [32:0] w_tab [0:gds_pkg::EXP_TABLE_DEPTH];
    logic [32:0] r_data;

    for (genvar k = 0; k <= gds_pkg::EXP_TABLE_DEPTH; k++) begin : g_tab
        assign w_tab[k] = gds_pkg::exp_entry(k);
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_tab[i_addr];
    end

    assign o_data = r_data;

endmodule

>>> design/gaussian_density_sweep.sv
// ----------------------------------------------------------------------------
// gaussian_density_sweep
// Steps x from start to end and returns the normal density at each point.
//
//  channel  dir  handshake             word
//  s        in   i_s_tvalid/o_s_tready  tdata[0] restart
//  m        out  o_m_tvalid/i_m_tready  tdata[15:0] abscissa, [31:16] density,
//                                       tlast last_point, tuser empty_sweep
//  cfg      in   i_cfg_valid/o_cfg_ready addr = register index, data = value
//
// A point takes two divider passes (|x-mean|/sigma, then the peak over sigma)
// and one exp(-1) multiply per whole unit of z^2/2; points with |z| >= 8 stop
// after the first pass and empty sweeps skip the arithmetic.
// The peak division overlaps the exp multiplies on the shared multiplier.
// A result waits in the output register while the next word is taken.
// Reset is synchronous; config is to be written only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module gaussian_density_sweep (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [0] restart
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [31:0]                 o_m_tdata,   // [15:0] abscissa, [31:16] density
    output logic                        o_m_tlast,   // last_point
    output logic                        o_m_tuser,   // [0] empty_sweep
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gds_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [15:0]                 i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_PICK, S_DIFF, S_QWAIT, S_SQ, S_FRAC, S_IDX, S_ROM,
        S_EXPM, S_EXPR, S_PEAKW, S_DENS, S_PUSH
    } t_state;

    t_state                      r_state;

    logic signed [15:0]          r_mean;
    logic [14:0]                 r_sigma;
    logic signed [15:0]          r_start;
    logic signed [15:0]          r_end;
    logic [14:0]                 r_step;

    logic signed [15:0]          r_cur;
    logic                        r_fresh;
    logic                        r_restart;

    logic signed [15:0]          r_x;
    logic [15:0]                 r_dens;
    logic                        r_last;
    logic                        r_empty;
    logic [14:0]                 r_q;
    logic [4:0]                  r_n;
    logic [32:0]                 r_e;

    logic                        r_ovalid;
    logic [31:0]                 r_otdata;
    logic                        r_olast;
    logic                        r_ouser;

    logic [14:0]                 w_step;
    logic [14:0]                 w_sigma;
    logic signed [17:0]          w_cur18;
    logic signed [17:0]          w_start18;
    logic signed [17:0]          w_end18;
    logic signed [17:0]          w_step18;
    logic signed [17:0]          w_xn;
    logic signed [17:0]          w_xn2;
    logic signed [17:0]          w_sn;
    logic                        w_fresh;
    logic                        w_empty;
    logic signed [15:0]          w_x;
    logic                        w_last;
    logic signed [16:0]          w_d;
    logic signed [16:0]          w_dneg;
    logic [15:0]                 w_absd;

    logic                        w_div_start;
    logic [gds_pkg::DIV_W-1:0]   w_div_dividend;
    logic [gds_pkg::DIV_W-1:0]   w_div_quo;
    gds_pkg::t_div_stat          w_div_stat;
    logic                        w_q_big;

    logic [32:0]                 w_mul_a;
    logic [31:0]                 w_mul_b;
    logic [64:0]                 w_mul_p;

    logic [47:0]                 w_idx_sum;
    logic [gds_pkg::IDX_W-1:0]   w_idx;
    logic [32:0]                 w_rom_q;
    logic [64:0]                 w_round;
    logic [64:0]                 w_dsum;
    logic [15:0]                 w_dens;

    // sweep arithmetic
    assign w_step    = (r_step == '0) ? 15'd1 : r_step;
    assign w_sigma   = (r_sigma == '0) ? 15'd1 : r_sigma;
    assign w_cur18   = 18'(r_cur);
    assign w_start18 = 18'(r_start);
    assign w_end18   = 18'(r_end);
    assign w_step18  = $signed({3'b000, w_step});
    assign w_xn      = w_cur18 + w_step18;
    assign w_xn2     = w_cur18 + (w_step18 <<< 1);
    assign w_sn      = w_start18 + w_step18;
    assign w_fresh   = r_fresh | r_restart | (w_xn > w_end18);
    assign w_empty   = w_fresh & (r_start > r_end);
    assign w_x       = w_fresh ? r_start : $signed(w_xn[15:0]);
    assign w_last    = w_fresh ? (w_sn > w_end18) : (w_xn2 > w_end18);

    assign w_d       = 17'(r_x) - 17'(r_mean);
    assign w_dneg    = -w_d;
    assign w_absd    = w_d[16] ? w_dneg[15:0] : w_d[15:0];

    assign w_q_big   = |w_div_quo[gds_pkg::DIV_W-1:15];

    assign w_idx_sum = w_mul_p[47:0] + 48'h80_0000;
    assign w_idx     = w_idx_sum[24 +: gds_pkg::IDX_W];
    assign w_round   = w_mul_p + 65'h8000_0000;
    assign w_dsum    = w_mul_p + (65'd1 << 39);
    assign w_dens    = (|w_dsum[64:56]) ? 16'hFFFF : w_dsum[55:40];

    always_comb begin
        w_div_start    = 1'b0;
        w_div_dividend = gds_pkg::PEAK_NUM;
        w_mul_a        = r_e;
        w_mul_b        = gds_pkg::EXP_LAST;
        case (r_state)
            S_DIFF: begin
                w_div_start    = 1'b1;
                w_div_dividend = gds_pkg::DIV_W'({w_absd, 12'd0});
            end
            S_QWAIT: begin
                w_div_start = w_div_stat.done && !w_q_big;
            end
            S_SQ: begin
                w_mul_a = 33'(r_q);
                w_mul_b = 32'(r_q);
            end
            S_FRAC: begin
                w_mul_a = 33'(w_mul_p[24:1]);
                w_mul_b = 32'(gds_pkg::EXP_TABLE_DEPTH);
            end
            S_PEAKW: begin
                w_mul_b = 32'(w_div_quo);
            end
            default: begin
            end
        endcase
    end

    gds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_sigma),
        .o_quo      (w_div_quo),
        .o_stat     (w_div_stat)
    );

    gds_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    gds_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (w_idx),
        .o_data (w_rom_q)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= 16'sd0;
            r_sigma <= 15'd256;
            r_start <= -16'sd768;
            r_end   <= 16'sd768;
            r_step  <= 15'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                gds_pkg::CFG_MEAN:  r_mean  <= $signed(i_cfg_data);
                gds_pkg::CFG_SIGMA: r_sigma <= i_cfg_data[14:0];
                gds_pkg::CFG_START: r_start <= $signed(i_cfg_data);
                gds_pkg::CFG_END:   r_end   <= $signed(i_cfg_data);
                gds_pkg::CFG_STEP:  r_step  <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cur    <= 16'sd0;
            r_fresh  <= 1'b1;
        end else begin
            if (r_ovalid && i_m_tready && (r_state != S_PUSH)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_restart <= i_s_tdata[0];
                        r_state   <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_empty <= w_empty;
                    r_dens  <= 16'd0;
                    if (w_empty) begin
                        r_x     <= r_start;
                        r_last  <= 1'b1;
                        r_fresh <= 1'b1;
                        r_state <= S_PUSH;
                    end else begin
                        r_x     <= w_x;
                        r_last  <= w_last;
                        r_cur   <= w_x;
                        r_fresh <= w_last;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_state <= S_QWAIT;
                end
                S_QWAIT: begin
                    if (w_div_stat.done) begin
                        r_q <= w_div_quo[14:0];
                        if (w_q_big) begin
                            r_dens  <= 16'd0;
                            r_state <= S_PUSH;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    r_state <= S_FRAC;
                end
                S_FRAC: begin
                    r_n     <= w_mul_p[29:25];
                    r_state <= S_IDX;
                end
                S_IDX: begin
                    r_state <= S_ROM;
                end
                S_ROM: begin
                    r_e     <= w_rom_q;
                    r_state <= (r_n == '0) ? S_PEAKW : S_EXPM;
                end
                S_EXPM: begin
                    r_n     <= r_n - 1'b1;
                    r_state <= S_EXPR;
                end
                S_EXPR: begin
                    r_e     <= w_round[64:32];
                    r_state <= (r_n == '0) ? S_PEAKW : S_EXPM;
                end
                S_PEAKW: begin
                    if (!w_div_stat.busy) begin
                        r_state <= S_DENS;
                    end
                end
                S_DENS: begin
                    r_dens  <= w_dens;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_otdata <= {r_dens, r_x};
                        r_olast  <= r_last;
                        r_ouser  <= r_empty;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_otdata;
    assign o_m_tlast   = r_olast;
    assign o_m_tuser   = r_ouser;
    assign o_cfg_ready = 1'b1;

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast && (o_m_tdata[31:16] == 16'd0))
        else $error("empty sweep word without last or with density");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider started while busy");

    a_exp_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PEAKW) |-> (r_n == 5'd0))
        else $error("exp loop left with count pending");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("not idle after reset");

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gaussian_density_sweep. Builds its own exp table
// and sweep predictor, programs a series of sweep settings (defaults,
// extremes, zero sigma and step, empty and overflowing sweeps, settings
// changed mid-sweep, then random ones) and checks every output word against
// the predicted point while both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LUT_D = gds_pkg::EXP_TABLE_DEPTH;
    localparam logic [gds_pkg::CFG_AW-1:0] CFG_NONE = 3'd7;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] abscissa;
        logic [15:0] density;
        logic        last_point;
        logic        empty_sweep;
    } point_t;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_s_tvalid  = 1'b0;
    logic                       o_s_tready;
    logic [7:0]                 i_s_tdata   = '0;   // [0] restart
    logic                       o_m_tvalid;
    logic                       i_m_tready  = 1'b0;
    logic [31:0]                o_m_tdata;          // [15:0] abscissa, [31:16] density
    logic                       o_m_tlast;          // last_point
    logic                       o_m_tuser;          // [0] empty_sweep
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [gds_pkg::CFG_AW-1:0] i_cfg_addr  = '0;
    logic [15:0]                i_cfg_data  = '0;

    gaussian_density_sweep i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor copy of the registers and sweep state
    int cfg_mean  = 0;
    int cfg_sigma = 256;
    int cfg_start = -768;
    int cfg_end   = 768;
    int cfg_step  = 64;
    int cur_x     = 0;
    bit at_start  = 1'b1;

    longint unsigned exp_lut [LUT_D+1];

    bit     pending_restart [$];
    point_t expected_points [$];

    int n_sent      = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int hold_mark   = 150;
    int idle_cycles = 0;
    int err_cnt     = 0;
    bit no_gaps     = 1'b0;

    function automatic int clamp16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 24);
        return $urandom_range(60, 200);
    endfunction

    function automatic logic [15:0] density_of(input int x);
        longint unsigned s, a, q, u, n, f, idx, e, peak, dens, j;
        int d;
        s = (cfg_sigma == 0) ? 1 : cfg_sigma;
        d = x - cfg_mean;
        a = (d < 0) ? longint'(-d) : longint'(d);
        q = (a << 12) / s;
        u = (q * q) >> 1;
        n = u >> 24;
        f = u & 64'hFF_FFFF;
        if (n >= 32) return 16'd0;
        idx = (f * LUT_D + 64'h80_0000) >> 24;
        if (idx > LUT_D) idx = LUT_D;
        e = exp_lut[idx];
        for (j = 0; j < n; j++)
            e = (e * exp_lut[LUT_D] + 64'h8000_0000) >> 32;
        peak = (64'd6693133 << 8) / s;
        dens = (peak * e + (64'd1 << 39)) >> 40;
        return (dens > 65535) ? 16'hFFFF : dens[15:0];
    endfunction

    function automatic point_t advance_sweep(input bit restart);
        int     stp, x, nx;
        bit     fresh, last;
        point_t pt;
        stp   = (cfg_step == 0) ? 1 : cfg_step;
        fresh = at_start || restart;
        x     = 0;
        if (!fresh) begin
            x = cur_x + stp;
            if (x > cfg_end || x > 32767) fresh = 1'b1;
        end
        if (fresh && cfg_start > cfg_end) begin
            at_start = 1'b1;
            pt = '{cfg_start[15:0], 16'd0, 1'b1, 1'b1};
            return pt;
        end
        if (fresh) x = cfg_start;
        nx   = x + stp;
        last = (nx > cfg_end) || (nx > 32767);
        cur_x    = x;
        at_start = last;
        pt = '{x[15:0], density_of(x), last, 1'b0};
        return pt;
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            gap_left   <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_points.push_back(advance_sweep(i_s_tdata[0]));
                n_sent <= n_sent + 1;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    i_s_tvalid <= 1'b0;
                    gap_left   <= gap_left - 1;
                end else if (pending_restart.size() != 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {7'd0, pending_restart.pop_front()};
                    gap_left   <= pick_gap();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with a long hold-off now and then
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (n_sent >= hold_mark) begin
            i_m_tready <= 1'b0;
            stall_left <= 600;
            hold_mark  <= hold_mark + 700;
        end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
            i_m_tready <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // output checker
    always @(posedge i_clk) begin : check_out
        point_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_points.size() == 0) begin
                $error("result word with no point pending: abscissa %0d",
                       $signed(o_m_tdata[15:0]));
                err_cnt++;
            end else begin
                want = expected_points.pop_front();
                if (o_m_tdata[15:0] !== want.abscissa) begin
                    $error("abscissa: expected %0d, got %0d",
                           $signed(want.abscissa), $signed(o_m_tdata[15:0]));
                    err_cnt++;
                end
                if (o_m_tdata[31:16] !== want.density) begin
                    $error("density: expected %0d, got %0d", want.density, o_m_tdata[31:16]);
                    err_cnt++;
                end
                if (o_m_tlast !== want.last_point) begin
                    $error("last_point: expected %0d, got %0d", want.last_point, o_m_tlast);
                    err_cnt++;
                end
                if (o_m_tuser !== want.empty_sweep) begin
                    $error("empty_sweep: expected %0d, got %0d", want.empty_sweep, o_m_tuser);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // call right after a rising edge; leaves valid high for the next write
    task automatic write_reg(input logic [gds_pkg::CFG_AW-1:0] addr, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (addr)
            gds_pkg::CFG_MEAN:  cfg_mean  = int'($signed(data));
            gds_pkg::CFG_SIGMA: cfg_sigma = int'(data[14:0]);
            gds_pkg::CFG_START: cfg_start = int'($signed(data));
            gds_pkg::CFG_END:   cfg_end   = int'($signed(data));
            gds_pkg::CFG_STEP:  cfg_step  = int'(data[14:0]);
            default: ;
        endcase
    endtask

    task automatic set_sweep(input int mu, input int sg, input int st, input int en,
                             input int stp);
        write_reg(gds_pkg::CFG_MEAN,  16'(mu));
        write_reg(gds_pkg::CFG_SIGMA, 16'(sg));
        write_reg(gds_pkg::CFG_START, 16'(st));
        write_reg(gds_pkg::CFG_END,   16'(en));
        write_reg(gds_pkg::CFG_STEP,  16'(stp));
        if ($urandom_range(0, 7) == 0) write_reg(CFG_NONE, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send(input bit restart);
        pending_restart.push_back(restart);
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending_restart.size() != 0 || i_s_tvalid || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stim
        longint unsigned k, i, term;
        longint          acc;
        int              r, total, n_items, odds, eff, sg, sg_eff, stp, st, en, mu, span;

        for (k = 0; k <= LUT_D; k++) begin
            acc  = longint'(1) << 40;
            term = 64'd1 << 40;
            i    = 1;
            while (term != 0 && i < 200) begin
                term = (term * k) / (LUT_D * i);
                if (i[0]) acc = acc - longint'(term);
                else      acc = acc + longint'(term);
                i++;
            end
            if (acc < 0) acc = 0;
            exp_lut[k] = (longint'(acc) + 128) >> 8;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, with a restart in the middle
        @(negedge i_clk);
        send(0); send(0); send(0); send(1); send(0); send(0);
        drain();

        // zero sigma and step, sweep running into the top of the range
        set_sweep(0, 0, 32765, 32767, 0);
        @(negedge i_clk);
        send(1); send(0); send(0); send(0);
        drain();

        // start above end
        set_sweep(0, 256, 100, -100, 64);
        @(negedge i_clk);
        send(0); send(0);
        drain();

        // full range, largest step, smallest sigma, mean at the bottom
        set_sweep(-32768, 1, -32768, 32767, 32767);
        @(negedge i_clk);
        send(0); send(0); send(0); send(0);
        drain();

        set_sweep(32767, 32767, -32768, 32767, 32767);
        @(negedge i_clk);
        send(1); send(0); send(0);
        drain();

        // end pulled below the running x
        set_sweep(0, 512, 0, 1000, 100);
        @(negedge i_clk);
        send(1); send(0); send(0);
        drain();
        set_sweep(0, 512, 0, 250, 100);
        @(negedge i_clk);
        send(0); send(0); send(0); send(0);
        drain();

        total = 27;
        while (total < 1600) begin
            r   = $urandom_range(0, 9);
            stp = (r == 0) ? 0 : (r == 1) ? 32767 :
                  (r < 6) ? $urandom_range(1, 256) : $urandom_range(257, 6000);
            if ($urandom_range(0, 15) == 0) stp = $urandom_range(0, 65535);
            eff = stp & 32'h7FFF;
            if (eff == 0) eff = 1;

            r  = $urandom_range(0, 9);
            sg = (r == 0) ? 0 : (r == 1) ? 32767 : (r == 2) ? 1 :
                 int'(eff * $urandom_range(1, 16) / 4 + $urandom_range(0, 64));
            if (sg > 32767) sg = 32767;
            if ($urandom_range(0, 15) == 0) sg = $urandom_range(0, 65535);
            sg_eff = sg & 32'h7FFF;

            r  = $urandom_range(0, 9);
            st = (r == 0) ? -32768 : (r == 1) ? clamp16(32767 - int'($urandom_range(0, 3)) * eff) :
                 int'($urandom_range(0, 65535)) - 32768;

            r  = $urandom_range(0, 9);
            en = (r == 0) ? 32767 : (r == 1) ? st - int'($urandom_range(1, 300)) :
                 st + eff * int'($urandom_range(0, 40)) + int'($urandom_range(0, eff - 1));
            en = clamp16(en);

            span = (en > st) ? en - st : 0;
            r  = $urandom_range(0, 9);
            mu = (r == 0) ? -32768 : (r == 1) ? 32767 :
                 st + int'($urandom_range(0, span)) + int'($urandom_range(0, 2 * sg_eff)) - sg_eff;
            mu = clamp16(mu);

            set_sweep(mu, sg, st, en, stp);
            no_gaps <= ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(10, 80);
            odds    = ($urandom_range(0, 5) == 0) ? 2 : 16;
            @(negedge i_clk);
            repeat (n_items) send($urandom_range(0, odds - 1) == 0);
            total += n_items;
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (expected_points.size() != 0) begin
            $error("%0d points never came out", expected_points.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
